>>> hw/rtl/etf_pkg.sv
// Package for the Ethernet transmit framer: state type, framing constants
// and the byte-wide CRC-32 update. No dependencies.
`timescale 1ns / 1ps

package etf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_SFD,
        ST_DATA,
        ST_FCS,
        ST_GAP
    } etf_state_t;

    localparam logic [7:0]  PREAMBLE_BYTE  = 8'h55;
    localparam logic [2:0]  PREAMBLE_LAST  = 3'd6;   // seven preamble bytes
    localparam logic [7:0]  SFD_BYTE       = 8'hD5;
    localparam logic [1:0]  FCS_LAST       = 2'd3;   // four FCS bytes
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [5:0]  GAP_MIN        = 6'd1;
    localparam logic [5:0]  GAP_MAX        = 6'd48;
    localparam logic [5:0]  GAP_RESET      = 6'd12;
    localparam logic [1:0]  ADDR_GAP       = 2'd0;   // register index of the gap count

    // Reflected CRC-32, one byte folded in LSB first.
    function automatic logic [31:0] crc32_fold_byte(input logic [31:0] crc_in,
                                                    input logic [7:0]  byte_in);
        logic [31:0] c;
        c = crc_in ^ {24'd0, byte_in};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/ethernet_tx_framer.sv
// Ethernet transmit framer: preamble/SFD insertion, CRC-32 FCS append and
// inter-packet gap. Depends on etf_pkg.
`timescale 1ns / 1ps

// Ethernet transmit framer. Payload items (payload_byte, frame_end) enter on
// in_valid/in_stall; the line stream leaves one result per cycle, while
// out_stall is low, on out_valid/out_stall as line_byte, line_enable and
// run_last, where run_last flags the final result of each item. The first
// item of a frame produces seven 0x55 preamble bytes, the 0xD5 delimiter and
// the payload byte. Middle items produce just the payload byte, so a frame
// body flows at one item per clock when not stalled. An item with frame_end
// set is followed by the four FCS bytes (complemented CRC-32, least
// significant byte first), then by as many idle results as the gap count
// (clamped to 1..48), with line_enable low and line_byte zero. The rate is
// set by the single output register, which takes one result per cycle when
// not stalled; the next item is taken in the cycle its predecessor's final
// result loads. Config register (6 bits, reset 12, any paddr): the user must
// write it over APB only while the framer is idle; the block does not enforce it.
module ethernet_tx_framer (
    input  logic        clk,
    input  logic        rst_n,
    // payload items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  payload_byte,
    input  logic        frame_end,
    // line stream
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  line_byte,
    output logic        line_enable,
    output logic        run_last,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import etf_pkg::*;

    // sequencer state and held item
    etf_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic [31:0] crc_reg, crc_next;
    logic        in_frame_reg, in_frame_next;
    logic [5:0]  gap_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  line_byte_reg;
    logic        line_enable_reg;
    logic        run_last_reg;

    // current result
    logic [7:0]  res_byte;
    logic        res_en;
    logic        res_final;

    logic        advance;
    logic        in_accept;
    logic        cfg_write;
    logic [5:0]  gap_clamped;
    logic [31:0] fcs_word;
    logic [31:0] fcs_shifted;

    // a result moves into the output register when it is empty or draining
    assign advance   = (state_reg != ST_IDLE) && (!out_valid_reg || !out_stall);
    // take a new item once the held one has loaded its final result
    assign in_stall  = (state_reg != ST_IDLE) && !(advance && res_final);
    assign in_accept = in_valid && !in_stall;

    assign gap_clamped = (gap_reg > GAP_MAX) ? GAP_MAX :
                         (gap_reg < GAP_MIN) ? GAP_MIN : gap_reg;

    assign fcs_word    = ~crc_reg;
    assign fcs_shifted = fcs_word >> {cnt_reg[1:0], 3'b000};

    // result of the current step
    always_comb
    begin
        res_byte  = 8'd0;
        res_en    = 1'b0;
        res_final = 1'b0;
        case (state_reg)
            ST_PRE:
            begin
                res_byte = PREAMBLE_BYTE;
                res_en   = 1'b1;
            end
            ST_SFD:
            begin
                res_byte = SFD_BYTE;
                res_en   = 1'b1;
            end
            ST_DATA:
            begin
                res_byte  = data_reg;
                res_en    = 1'b1;
                res_final = !last_reg;
            end
            ST_FCS:
            begin
                res_byte = fcs_shifted[7:0];
                res_en   = 1'b1;
            end
            ST_GAP:
            begin
                res_final = (cnt_reg == 6'd1);
            end
            default:
            begin
                res_byte  = 8'd0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;

        if (advance) begin
            case (state_reg)
                ST_PRE:
                begin
                    in_frame_next = 1'b1;
                    if (cnt_reg[2:0] == PREAMBLE_LAST) begin
                        state_next = ST_SFD;
                    end
                    else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
                ST_SFD:
                begin
                    state_next = ST_DATA;
                end
                ST_DATA:
                begin
                    crc_next = crc32_fold_byte(crc_reg, data_reg);
                    if (last_reg) begin
                        state_next = ST_FCS;
                        cnt_next   = 6'd0;
                    end
                    else begin
                        state_next = ST_IDLE;
                    end
                end
                ST_FCS:
                begin
                    if (cnt_reg[1:0] == FCS_LAST) begin
                        state_next    = ST_GAP;
                        cnt_next      = gap_clamped;
                        crc_next      = CRC_INIT;
                        in_frame_next = 1'b0;
                    end
                    else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
                ST_GAP:
                begin
                    if (cnt_reg == 6'd1) begin
                        state_next = ST_IDLE;
                    end
                    else begin
                        cnt_next = cnt_reg - 6'd1;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        // a new item overrides the step that just finished the old one
        if (in_accept) begin
            data_next  = payload_byte;
            last_next  = frame_end;
            cnt_next   = 6'd0;
            state_next = in_frame_next ? ST_DATA : ST_PRE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= 6'd0;
            crc_reg      <= CRC_INIT;
            in_frame_reg <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            line_byte_reg   <= res_byte;
            line_enable_reg <= res_en;
            run_last_reg    <= res_final;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_byte   = line_byte_reg;
    assign line_enable = line_enable_reg;
    assign run_last    = run_last_reg;

    // config register; byte offset within the word is ignored
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gap_reg <= GAP_RESET;
        end
        else if (cfg_write && ((paddr >> 2) == ADDR_GAP)) begin
            gap_reg <= pwdata[5:0];
        end
    end

    assign prdata = {26'd0, gap_reg};
    assign pready = 1'b1;

    // checks
    a_idle_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !in_stall)
        else $error("framer stalls input while idle");

    a_fcs_to_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg == ST_FCS && cnt_reg[1:0] == FCS_LAST)
            |=> (state_reg == ST_GAP && !in_frame_reg && crc_reg == CRC_INIT))
        else $error("frame did not close after FCS");

    a_gap_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GAP) |-> (cnt_reg != 6'd0 && cnt_reg <= GAP_MAX))
        else $error("gap count out of range");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !line_enable) |-> (line_byte == 8'd0))
        else $error("nonzero byte during gap");

endmodule

>>> sim/ethernet_tx_framer_test.sv
// Self-checking testbench for ethernet_tx_framer: preamble/SFD, payload pass-through,
// CRC-32 FCS and inter-packet gap predicted per item, checked on every line result.
// Depends on etf_pkg and the ethernet_tx_framer RTL.
`timescale 1ns / 1ps

module ethernet_tx_framer_test;

    import etf_pkg::*;

    localparam int QUIET_LIMIT = 3000;   // cycles with nothing accepted before giving up

    typedef struct {
        logic [7:0] data;
        logic       en;
        logic       last;
    } line_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  payload_byte = 8'd0;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  line_byte;
    logic        line_enable;
    logic        run_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic        frame_open;
    logic [31:0] crc_run;
    logic [5:0]  gap_setting;

    line_beat_t  pending_line_q[$];
    int          error_count = 0;
    int          lines_seen = 0;
    bit          idle_on = 1'b1;

    ethernet_tx_framer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_byte    (line_byte),
        .line_enable  (line_enable),
        .run_last     (run_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Reflected CRC-32, data bits taken LSB first.
    function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic push_beat(input logic [7:0] d, input logic en, input logic last);
        line_beat_t beat;
        beat.data = d;
        beat.en   = en;
        beat.last = last;
        pending_line_q.push_back(beat);
    endtask

    // Line results caused by one accepted payload item.
    task automatic append_line_beats(input logic [7:0] d, input logic fin);
        logic [31:0] fcs;
        int          gap;
        if (!frame_open)
        begin
            for (int k = 0; k < 7; k++)
            begin
                push_beat(PREAMBLE_BYTE, 1'b1, 1'b0);
            end
            push_beat(SFD_BYTE, 1'b1, 1'b0);
            frame_open = 1'b1;
            crc_run    = CRC_INIT;
        end
        push_beat(d, 1'b1, !fin);
        crc_run = crc32_next(crc_run, d);
        if (fin)
        begin
            fcs = ~crc_run;
            for (int k = 0; k < 4; k++)
            begin
                push_beat(fcs[8*k +: 8], 1'b1, 1'b0);
            end
            // the gap count used saturates into 1..48
            gap = int'(gap_setting);
            if (gap > int'(GAP_MAX))
            begin
                gap = int'(GAP_MAX);
            end
            if (gap < int'(GAP_MIN))
            begin
                gap = int'(GAP_MIN);
            end
            for (int k = 0; k < gap; k++)
            begin
                push_beat(8'd0, 1'b0, k == gap - 1);
            end
            frame_open = 1'b0;
            crc_run    = CRC_INIT;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("ERROR @%0t line result %0d: %s: expected %0h, got %0h",
                 $realtime, lines_seen, what, want, got);
        error_count++;
    endtask

    initial
    begin
        line_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_line_q.size() == 0)
                begin
                    report_mismatch("unexpected result", 0, line_byte);
                end
                else
                begin
                    want = pending_line_q.pop_front();
                    if (line_byte !== want.data)
                    begin
                        report_mismatch("line_byte", want.data, line_byte);
                    end
                    if (line_enable !== want.en)
                    begin
                        report_mismatch("line_enable", want.en, line_enable);
                    end
                    if (run_last !== want.last)
                    begin
                        report_mismatch("run_last", want.last, run_last);
                    end
                end
                lines_seen++;
            end
        end
    end

    // Receiver stall: random stall bursts while idling is on.
    initial
    begin
        int left;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left > 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else if (idle_on && rst_n && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                left = $urandom_range(1, 17) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
        $display("** ethernet_tx_framer: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driving (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------

    // Leaves in_valid high so back-to-back items need no extra assignment.
    task automatic send_item(input logic [7:0] d, input logic fin);
        int n;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 17);
            in_valid     <= 1'b0;
            payload_byte <= 8'($urandom);
            frame_end    <= 1'($urandom);
            repeat (n) @(negedge clk);
        end
        in_valid     <= 1'b1;
        payload_byte <= d;
        frame_end    <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        append_line_beats(d, fin);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_line_q.size() != 0);
    endtask

    // Gap register write; only done with the framer idle between frames.
    task automatic set_gap_cycles(input logic [5:0] val);
        logic [31:0] upper;
        upper = $urandom;
        wait_drained();
        repeat (8) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_GAP;
        pwdata  <= {upper[31:6], val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        gap_setting = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_frame(input int len);
        for (int k = 0; k < len; k++)
        begin
            send_item(8'($urandom), k == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One-byte frame with the gap count straight out of reset.
    task automatic test_reset_gap();
        send_item(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_directed_frames();
        logic [7:0] check_str[9];
        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        send_item(8'hFF, 1'b1);
        // all-zero byte opening a frame, all-one byte mid frame
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b1);
        // "123456789": CRC check value 0xCBF43926
        foreach (check_str[k])
        begin
            send_item(check_str[k], k == 8);
        end
    endtask

    // Gap zero acts as one, 49..63 saturate to 48.
    task automatic test_gap_settings();
        logic [5:0] vals[5];
        vals = '{6'd0, 6'd1, 6'd48, 6'd49, 6'd63};
        foreach (vals[k])
        begin
            set_gap_cycles(vals[k]);
            send_item(8'($urandom), 1'b1);
        end
    endtask

    // Sender holds off until every expected result is out, then resumes.
    task automatic test_drain_pause();
        set_gap_cycles(6'd3);
        send_frame(5);
        send_frame(1);
        wait_drained();
        send_frame(7);
    endtask

    task automatic test_random_traffic(input int target);
        int sent;
        int next_cfg;
        int len;
        logic [5:0] g;
        sent     = 0;
        next_cfg = 0;
        while (sent < target)
        begin
            if (sent >= next_cfg)
            begin
                case ($urandom_range(0, 3))
                    0:       g = 6'($urandom_range(0, 1));
                    1:       g = 6'($urandom_range(47, 63));
                    default: g = 6'($urandom_range(1, 20));
                endcase
                set_gap_cycles(g);
                next_cfg += 100;
            end
            // quiet stretch mid run, and no idling at all toward the end
            idle_on = !((sent >= 200 && sent < 260) || sent >= target - 60);
            case ($urandom_range(0, 19))
                0:          len = $urandom_range(41, 100);
                1, 2, 3, 4: len = $urandom_range(9, 40);
                default:    len = $urandom_range(1, 8);
            endcase
            send_frame(len);
            sent += len;
        end
    endtask

    initial
    begin
        frame_open  = 1'b0;
        crc_run     = CRC_INIT;
        gap_setting = GAP_RESET;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_gap();
        test_directed_frames();
        test_gap_settings();
        test_drain_pause();
        test_random_traffic(500);

        wait_drained();
        repeat (64) @(negedge clk);
        if (pending_line_q.size() != 0)
        begin
            report_mismatch("results never arrived", pending_line_q.size(), 0);
        end
        if (error_count == 0)
        begin
            $display("** ethernet_tx_framer: PASSED **");
        end
        else
        begin
            $display("** ethernet_tx_framer: FAILED **");
        end
        $finish;
    end

endmodule

>>> ethernet_tx_framer.f
hw/rtl/etf_pkg.sv
hw/rtl/ethernet_tx_framer.sv
sim/ethernet_tx_framer_test.sv
